// ===== sv/blrc_pkg.sv =====
package blrc_pkg;

  // Field widths.
  localparam int unsigned LevelW = 14;
  localparam int unsigned AlphaW = 16;
  localparam int unsigned RateW  = 24;
  localparam int unsigned FpaW   = 4;
  localparam int unsigned SkewW  = 12;
  localparam int unsigned TrendW = 18;
  localparam int unsigned AccW   = 30;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Sums of the slope fit, sized for a history of up to 64 entries.
  localparam int unsigned NW   = 7;
  localparam int unsigned NsqW = 12;
  localparam int unsigned SxW  = 11;
  localparam int unsigned SyW  = 21;
  localparam int unsigned SxxW = 17;
  localparam int unsigned SxyW = 25;
  localparam int unsigned DenW = 23;

  // Shared multiplier operands and product.
  localparam int unsigned MulAW = 17;
  localparam int unsigned MulBW = 30;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Shared divider.
  localparam int unsigned DvdW = 41;
  localparam int unsigned DvsW = DenW;
  localparam int unsigned DivCntW = 6;

  // Reset values of the registers.
  localparam logic [LevelW-1:0] TargetRst  = 14'd5000;
  localparam logic [AlphaW-1:0] AlphaRst   = 16'd3277;
  localparam logic [RateW-1:0]  FloorRst   = 24'd12042240;
  localparam logic [RateW-1:0]  CeilRst    = 24'd12533760;
  localparam logic [RateW-1:0]  StartRst   = 24'd12288000;
  localparam logic [FpaW-1:0]   FpaRst     = 4'd3;
  localparam logic [SkewW-1:0]  SkewDivRst = 12'd160;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET  = 3'd0,
    CFG_ALPHA   = 3'd1,
    CFG_FLOOR   = 3'd2,
    CFG_CEILING = 3'd3,
    CFG_START   = 3'd4,
    CFG_FPA     = 3'd5,
    CFG_SKEWDIV = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                start;
    logic [DivCntW-1:0]  iters;
    logic [DvdW-1:0]     dividend;
    logic [DvsW-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/buffer_level_rate_controller.sv =====
// Rate controller for an audio playback buffer. Each item carries the free space measured once
// per frame; the block smooths it, keeps it in a history ring and returns the output sample
// rate, the smoothed level, the last fitted trend and a flag for frames that adjusted the rate.
// A frame that does not adjust only smooths and stores its sample. An adjusting frame also
// walks the history memory at one entry a cycle, runs a few products through the single shared
// multiplier, then makes two passes through the bit-serial divider (41 steps for the slope,
// skipped when the denominator is zero, 22 for the skew term). The input stalls meanwhile; a
// finished item waits in the output register while the next one is taken.
module buffer_level_rate_controller #(
  parameter int unsigned HISTORY_DEPTH = 60
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [blrc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [blrc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [blrc_pkg::LevelW-1:0]       free_bytes_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [blrc_pkg::RateW-1:0]        playback_rate_o,
  output logic [blrc_pkg::LevelW-1:0]       smoothed_level_o,
  output logic signed [blrc_pkg::TrendW-1:0] trend_o,
  output logic                              adjusted_o
);

  localparam int unsigned PtrW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned WalkW = $clog2(HISTORY_DEPTH + 3);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(HISTORY_DEPTH - 1);
  localparam logic [WalkW-1:0] WalkEnd = WalkW'(HISTORY_DEPTH);
  localparam logic [WalkW-1:0] WalkFin = WalkW'(HISTORY_DEPTH + 1);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_AVG1 = 16'h0002,
    S_AVG2 = 16'h0004,
    S_AVG3 = 16'h0008,
    S_WALK = 16'h0010,
    S_M1   = 16'h0020,
    S_M2   = 16'h0040,
    S_M3   = 16'h0080,
    S_M4   = 16'h0100,
    S_M5   = 16'h0200,
    S_DIVS = 16'h0400,
    S_DIVW = 16'h0800,
    S_SKS  = 16'h1000,
    S_SKW  = 16'h2000,
    S_ADJ  = 16'h4000,
    S_DONE = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers; the start rate only applies at reset.
  logic [blrc_pkg::LevelW-1:0] target_q;
  logic [blrc_pkg::AlphaW-1:0] alpha_q;
  logic [blrc_pkg::RateW-1:0]  floor_q, ceil_q;
  logic [blrc_pkg::FpaW-1:0]   fpa_q;
  logic [blrc_pkg::SkewW-1:0]  skewdiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= blrc_pkg::TargetRst;
      alpha_q   <= blrc_pkg::AlphaRst;
      floor_q   <= blrc_pkg::FloorRst;
      ceil_q    <= blrc_pkg::CeilRst;
      fpa_q     <= blrc_pkg::FpaRst;
      skewdiv_q <= blrc_pkg::SkewDivRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blrc_pkg::CFG_TARGET:  target_q  <= cfg_wdata_i[blrc_pkg::LevelW-1:0];
        blrc_pkg::CFG_ALPHA:   alpha_q   <= cfg_wdata_i[blrc_pkg::AlphaW-1:0];
        blrc_pkg::CFG_FLOOR:   floor_q   <= cfg_wdata_i[blrc_pkg::RateW-1:0];
        blrc_pkg::CFG_CEILING: ceil_q    <= cfg_wdata_i[blrc_pkg::RateW-1:0];
        blrc_pkg::CFG_START:   ;
        blrc_pkg::CFG_FPA:     fpa_q     <= cfg_wdata_i[blrc_pkg::FpaW-1:0];
        blrc_pkg::CFG_SKEWDIV: skewdiv_q <= cfg_wdata_i[blrc_pkg::SkewW-1:0];
        default: ;
      endcase
    end
  end

  // Control and state registers.
  logic                            out_valid_q, out_valid_d;
  logic [HISTORY_DEPTH-1:0]        hvalid_q, hvalid_d;
  logic [PtrW-1:0]                 ptr_q, ptr_d;
  logic [PtrW-1:0]                 rd_ptr_q, rd_ptr_d;
  logic [WalkW-1:0]                walk_q, walk_d;
  logic                            hit_q, hit_d, hit2_q, hit2_d;
  logic [blrc_pkg::AccW-1:0]       acc_q, acc_d;
  logic [blrc_pkg::FpaW-1:0]       fua_q, fua_d;
  logic [blrc_pkg::RateW-1:0]      rate_q, rate_d;
  logic signed [blrc_pkg::TrendW-1:0] trend_q, trend_d;
  logic                            did_q, did_d;

  // Payload and working registers.
  logic [blrc_pkg::LevelW-1:0]     w_q, w_d;
  logic [blrc_pkg::LevelW-1:0]     level_q, level_d;
  logic [blrc_pkg::AccW:0]         kept_q, kept_d;
  logic [blrc_pkg::MulPW-1:0]      mp_q;
  logic [31:0]                     t1_q, t1_d;
  logic [blrc_pkg::NW-1:0]         n_q, n_d;
  logic [blrc_pkg::NsqW-1:0]       nsq_q, nsq_d;
  logic [blrc_pkg::SxW-1:0]        sx_q, sx_d;
  logic [blrc_pkg::SyW-1:0]        sy_q, sy_d;
  logic [blrc_pkg::SxxW-1:0]       sxx_q, sxx_d;
  logic [blrc_pkg::SxyW-1:0]       sxy_q, sxy_d;
  logic signed [32:0]              num_q, num_d;
  logic [blrc_pkg::DenW-1:0]       den_q, den_d;
  logic [21:0]                     skew_q, skew_d;
  logic [blrc_pkg::RateW-1:0]      o_rate_q, o_rate_d;
  logic [blrc_pkg::LevelW-1:0]     o_level_q, o_level_d;
  logic signed [blrc_pkg::TrendW-1:0] o_trend_q, o_trend_d;
  logic                            o_adj_q, o_adj_d;

  // History memory.
  logic [blrc_pkg::LevelW-1:0] hist_mem [HISTORY_DEPTH];
  logic [blrc_pkg::LevelW-1:0] rd_data_q;
  logic                        wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[ptr_q] <= level_d;
    end
    rd_data_q <= hist_mem[rd_ptr_q];
  end

  // Shared multiplier, product registered.
  logic [blrc_pkg::MulAW-1:0] mul_a;
  logic [blrc_pkg::MulBW-1:0] mul_b;

  always_ff @(posedge clk_i) begin
    mp_q <= blrc_pkg::MulPW'(mul_a) * blrc_pkg::MulPW'(mul_b);
  end

  // Shared divider.
  blrc_pkg::div_req_t div_req;
  blrc_pkg::div_rsp_t div_rsp;

  blrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Adjustment terms.
  logic [blrc_pkg::TrendW-1:0] abs_trend;
  logic [blrc_pkg::LevelW-1:0] abs_diff;
  logic                        dir_pos, dir_neg, brake, push;
  logic [8:0]                  brake_amt;
  logic [22:0]                 push_sum;
  logic [9:0]                  push_amt;
  logic signed [25:0]          rate_new;
  logic [blrc_pkg::DvdW-1:0]   quot_mag;
  logic [32:0]                 num_mag;
  logic [blrc_pkg::AccW:0]     acc_sum;
  logic out_free;

  always_comb begin
    dir_pos   = level_q > target_q;
    dir_neg   = level_q < target_q;
    abs_diff  = dir_pos ? level_q - target_q : target_q - level_q;
    abs_trend = trend_q[blrc_pkg::TrendW-1] ? blrc_pkg::TrendW'(-trend_q)
                                            : blrc_pkg::TrendW'(trend_q);
    brake = (dir_pos && (trend_q < -18'sd256)) || (dir_neg && (trend_q > 18'sd256));
    push  = (dir_pos && (trend_q > 18'sd0)) || (dir_neg && (trend_q < 18'sd0))
            || (level_q == '0);
    brake_amt = (abs_trend[17:2] > 16'd256) ? 9'd256 : abs_trend[10:2];
    push_sum  = 23'(abs_trend) + 23'(skew_q);
    push_amt  = (push_sum[22:1] > 22'd512) ? 10'd512 : push_sum[10:1];
    rate_new  = $signed({2'b00, rate_q});
    if (brake) begin
      rate_new = dir_pos ? rate_new - $signed({16'd0, brake_amt})
                         : rate_new + $signed({16'd0, brake_amt});
    end else if (push) begin
      if (dir_pos) begin
        rate_new = rate_new + $signed({16'd0, push_amt});
      end else if (dir_neg) begin
        rate_new = rate_new - $signed({16'd0, push_amt});
      end
    end
    num_mag  = num_q[32] ? 33'(-num_q) : 33'(num_q);
    quot_mag = div_rsp.quot;
    acc_sum  = kept_q + mp_q[blrc_pkg::AccW:0];
    out_free = !out_valid_q || !out_stall_i;
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    hvalid_d    = hvalid_q;
    ptr_d       = ptr_q;
    rd_ptr_d    = rd_ptr_q;
    walk_d      = walk_q;
    hit_d       = 1'b0;
    hit2_d      = hit_q;
    acc_d       = acc_q;
    fua_d       = fua_q;
    rate_d      = rate_q;
    trend_d     = trend_q;
    did_d       = did_q;
    w_d         = w_q;
    level_d     = level_q;
    kept_d      = kept_q;
    t1_d        = t1_q;
    n_d         = n_q;
    nsq_d       = nsq_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxx_d       = sxx_q;
    sxy_d       = sxy_q;
    num_d       = num_q;
    den_d       = den_q;
    skew_d      = skew_q;
    o_rate_d    = o_rate_q;
    o_level_d   = o_level_q;
    o_trend_d   = o_trend_q;
    o_adj_d     = o_adj_q;
    wr_en       = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          w_d     = free_bytes_i;
          state_d = S_AVG1;
        end
      end
      // Decay the average, then add the weighted new sample.
      S_AVG1: begin
        mul_a   = 17'd65536 - {1'b0, alpha_q};
        mul_b   = acc_q;
        state_d = S_AVG2;
      end
      S_AVG2: begin
        kept_d  = mp_q[blrc_pkg::MulPW-1:16];
        mul_a   = {1'b0, alpha_q};
        mul_b   = {16'd0, w_q};
        state_d = S_AVG3;
      end
      // Store the level, advance the ring and count down to the next fit.
      S_AVG3: begin
        acc_d   = acc_sum[blrc_pkg::AccW-1:0];
        level_d = acc_sum[blrc_pkg::AccW-1:16];
        wr_en   = 1'b1;
        hvalid_d[ptr_q] = 1'b1;
        ptr_d    = (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
        rd_ptr_d = ptr_d;
        fua_d    = fua_q - 1'b1;
        walk_d   = '0;
        n_d      = '0;
        nsq_d    = '0;
        sx_d     = '0;
        sy_d     = '0;
        sxx_d    = '0;
        sxy_d    = '0;
        if (fua_d == '0) begin
          fua_d   = fpa_q;
          did_d   = 1'b1;
          state_d = S_WALK;
        end else begin
          did_d   = 1'b0;
          state_d = S_DONE;
        end
      end
      // Walk the ring oldest first; read, accumulate, then add the product.
      S_WALK: begin
        if (walk_q < WalkEnd) begin
          hit_d    = hvalid_q[rd_ptr_q];
          rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
        end
        if (hit_q) begin
          mul_a = 17'(n_q);
          mul_b = 30'(rd_data_q);
          sx_d  = sx_q + 11'(n_q);
          sy_d  = sy_q + 21'(rd_data_q);
          sxx_d = sxx_q + 17'(nsq_q);
          nsq_d = nsq_q + {4'd0, n_q, 1'b1};
          n_d   = n_q + 1'b1;
        end
        if (hit2_q) begin
          sxy_d = sxy_q + mp_q[blrc_pkg::SxyW-1:0];
        end
        walk_d = walk_q + 1'b1;
        if (walk_q == WalkFin) begin
          state_d = S_M1;
        end
      end
      // Numerator and denominator of the least-squares slope.
      S_M1: begin
        mul_a   = 17'(n_q);
        mul_b   = 30'(sxy_q);
        state_d = S_M2;
      end
      S_M2: begin
        t1_d    = mp_q[31:0];
        mul_a   = 17'(sx_q);
        mul_b   = 30'(sy_q);
        state_d = S_M3;
      end
      S_M3: begin
        num_d   = $signed({1'b0, t1_q}) - $signed({1'b0, mp_q[31:0]});
        mul_a   = 17'(n_q);
        mul_b   = 30'(sxx_q);
        state_d = S_M4;
      end
      S_M4: begin
        t1_d    = mp_q[31:0];
        mul_a   = 17'(sx_q);
        mul_b   = 30'(sx_q);
        state_d = S_M5;
      end
      S_M5: begin
        den_d = blrc_pkg::DenW'(t1_q - mp_q[31:0]);
        if (den_d == '0) begin
          trend_d = '0;
          state_d = S_SKS;
        end else begin
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        div_req.start    = 1'b1;
        div_req.iters    = blrc_pkg::DivCntW'(blrc_pkg::DvdW);
        div_req.dividend = {num_mag, 8'd0};
        div_req.divisor  = den_q;
        state_d          = S_DIVW;
      end
      // Saturate the slope quotient to the trend range.
      S_DIVW: begin
        if (div_rsp.done) begin
          if (num_q[32]) begin
            trend_d = (quot_mag > 41'd131072) ? -18'sd131072
                                              : -$signed(quot_mag[17:0]);
          end else begin
            trend_d = (quot_mag > 41'd131071) ? 18'sd131071
                                              : $signed(quot_mag[17:0]);
          end
          state_d = S_SKS;
        end
      end
      S_SKS: begin
        div_req.start    = 1'b1;
        div_req.iters    = 6'd22;
        div_req.dividend = {abs_diff, 27'd0};
        div_req.divisor  = (skewdiv_q == '0) ? 23'd1 : 23'(skewdiv_q);
        state_d          = S_SKW;
      end
      S_SKW: begin
        if (div_rsp.done) begin
          skew_d  = div_rsp.quot[21:0];
          state_d = S_ADJ;
        end
      end
      // Nudge the rate and clamp, floor first.
      S_ADJ: begin
        if (rate_new < $signed({2'b00, floor_q})) begin
          rate_d = floor_q;
        end else if (rate_new > $signed({2'b00, ceil_q})) begin
          rate_d = ceil_q;
        end else begin
          rate_d = rate_new[blrc_pkg::RateW-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_rate_d    = rate_q;
          o_level_d   = level_q;
          o_trend_d   = trend_q;
          o_adj_d     = did_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hvalid_q    <= '0;
      ptr_q       <= '0;
      rd_ptr_q    <= '0;
      walk_q      <= '0;
      hit_q       <= 1'b0;
      hit2_q      <= 1'b0;
      acc_q       <= '0;
      fua_q       <= blrc_pkg::FpaRst;
      rate_q      <= blrc_pkg::StartRst;
      trend_q     <= '0;
      did_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hvalid_q    <= hvalid_d;
      ptr_q       <= ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      walk_q      <= walk_d;
      hit_q       <= hit_d;
      hit2_q      <= hit2_d;
      acc_q       <= acc_d;
      fua_q       <= fua_d;
      rate_q      <= rate_d;
      trend_q     <= trend_d;
      did_q       <= did_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    level_q   <= level_d;
    kept_q    <= kept_d;
    t1_q      <= t1_d;
    n_q       <= n_d;
    nsq_q     <= nsq_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    sxx_q     <= sxx_d;
    sxy_q     <= sxy_d;
    num_q     <= num_d;
    den_q     <= den_d;
    skew_q    <= skew_d;
    o_rate_q  <= o_rate_d;
    o_level_q <= o_level_d;
    o_trend_q <= o_trend_d;
    o_adj_q   <= o_adj_d;
  end

  // Ports.
  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign playback_rate_o  = o_rate_q;
  assign smoothed_level_o = o_level_q;
  assign trend_o          = o_trend_q;
  assign adjusted_o       = o_adj_q;

endmodule

// ===== sv/blrc_div.sv =====
module blrc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blrc_pkg::div_req_t req_i,
  output blrc_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [blrc_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic [blrc_pkg::DvsW-1:0]     rem_q, rem_d;
  logic [blrc_pkg::DvdW-1:0]     dvd_q, dvd_d;
  logic [blrc_pkg::DvsW-1:0]     dvs_q, dvs_d;
  logic [blrc_pkg::DvsW:0]       shifted;
  logic                          fits;

  // One restoring step a cycle; quotient bits shift in below the dividend.
  always_comb begin
    shifted = {rem_q, dvd_q[blrc_pkg::DvdW-1]};
    fits    = shifted >= {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? blrc_pkg::DvsW'(shifted - {1'b0, dvs_q})
                   : shifted[blrc_pkg::DvsW-1:0];
      dvd_d = {dvd_q[blrc_pkg::DvdW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == blrc_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

// ===== sim/blrc_checker.sv =====
module blrc_checker #(
  parameter int unsigned HistDepth = 60
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [blrc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [blrc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [blrc_pkg::LevelW-1:0]        free_bytes_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [blrc_pkg::RateW-1:0]         playback_rate_i,
  input  logic [blrc_pkg::LevelW-1:0]        smoothed_level_i,
  input  logic signed [blrc_pkg::TrendW-1:0] trend_i,
  input  logic                               adjusted_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        frames_o,
  output int unsigned                        adjusts_o
);

  typedef struct packed {
    logic [blrc_pkg::RateW-1:0]         rate;
    logic [blrc_pkg::LevelW-1:0]        level;
    logic signed [blrc_pkg::TrendW-1:0] trend;
    logic                               adjusted;
  } frame_result_t;

  // Shadow copy of the registers.
  logic [blrc_pkg::LevelW-1:0] target_q;
  logic [blrc_pkg::AlphaW-1:0] alpha_q;
  logic [blrc_pkg::RateW-1:0]  floor_q;
  logic [blrc_pkg::RateW-1:0]  ceil_q;
  logic [blrc_pkg::FpaW-1:0]   fpa_q;
  logic [blrc_pkg::SkewW-1:0]  skew_div_q;

  // Shadow copy of the controller state.
  logic [blrc_pkg::LevelW-1:0]        hist_level[HistDepth];
  logic                               hist_valid[HistDepth];
  int unsigned                        hist_ptr;
  logic [blrc_pkg::AccW-1:0]          avg_acc;
  logic [blrc_pkg::FpaW-1:0]          frames_left;
  logic [blrc_pkg::RateW-1:0]         rate_q;
  logic signed [blrc_pkg::TrendW-1:0] trend_q;

  frame_result_t expected_results[$];

  // Least-squares slope over the valid history, oldest entry first, in Q.8.
  function automatic logic signed [blrc_pkg::TrendW-1:0] fit_trend();
    longint n, sx, sy, sxx, sxy, num, den, q;
    int unsigned pos;
    n = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
    pos = hist_ptr;
    for (int j = 0; j < HistDepth; j++) begin
      if (hist_valid[pos]) begin
        sx += n;
        sy += longint'(hist_level[pos]);
        sxx += n * n;
        sxy += n * longint'(hist_level[pos]);
        n++;
      end
      pos = (pos + 1) % HistDepth;
    end
    num = n * sxy - sx * sy;
    den = n * sxx - sx * sx;
    if (den <= 0) return '0;
    q = (num * 256) / den;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q[blrc_pkg::TrendW-1:0];
  endfunction

  // Nudge the rate toward the target level, then clamp it.
  function automatic logic [blrc_pkg::RateW-1:0] next_rate(logic [blrc_pkg::LevelW-1:0] level);
    longint diff, dir, t, abs_t, abs_d, step, m, dv, r;
    diff = longint'(level) - longint'(target_q);
    dir = (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
    t = longint'(trend_q);
    abs_t = (t < 0) ? -t : t;
    abs_d = (diff < 0) ? -diff : diff;
    step = 0;
    if (dir * t < -256) begin
      m = abs_t >>> 2;
      step = (m > 256) ? 256 : m;
    end else if (dir * t > 0 || level == 0) begin
      dv = (skew_div_q == 0) ? 1 : longint'(skew_div_q);
      m = (abs_t + (abs_d * 256) / dv) >>> 1;
      step = -((m > 512) ? 512 : m);
    end
    r = longint'(rate_q) - dir * step;
    if (r < longint'(floor_q)) r = longint'(floor_q);
    else if (r > longint'(ceil_q)) r = longint'(ceil_q);
    return r[blrc_pkg::RateW-1:0];
  endfunction

  // Advance the shadow state by one frame and return what the block should report.
  function automatic frame_result_t predict_frame(logic [blrc_pkg::LevelW-1:0] free_bytes);
    frame_result_t res;
    longint kept;
    logic [blrc_pkg::LevelW-1:0] level;
    kept = (longint'(avg_acc) * (65536 - longint'(alpha_q))) >>> 16;
    avg_acc = blrc_pkg::AccW'(kept + longint'(free_bytes) * longint'(alpha_q));
    level = avg_acc[blrc_pkg::AccW-1:16];
    hist_level[hist_ptr] = level;
    hist_valid[hist_ptr] = 1'b1;
    hist_ptr = (hist_ptr + 1) % HistDepth;
    frames_left = frames_left - 1'b1;
    res.adjusted = 1'b0;
    if (frames_left == 0) begin
      trend_q = fit_trend();
      frames_left = fpa_q;
      rate_q = next_rate(level);
      res.adjusted = 1'b1;
    end
    res.rate = rate_q;
    res.level = level;
    res.trend = trend_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t exp_r;
    if (!rst_ni) begin
      target_q = blrc_pkg::TargetRst;
      alpha_q = blrc_pkg::AlphaRst;
      floor_q = blrc_pkg::FloorRst;
      ceil_q = blrc_pkg::CeilRst;
      fpa_q = blrc_pkg::FpaRst;
      skew_div_q = blrc_pkg::SkewDivRst;
      for (int i = 0; i < HistDepth; i++) begin
        hist_level[i] = '0;
        hist_valid[i] = 1'b0;
      end
      hist_ptr = 0;
      avg_acc = '0;
      frames_left = blrc_pkg::FpaRst;
      rate_q = blrc_pkg::StartRst;
      trend_q = '0;
      expected_results.delete();
      fail_count_o = 0;
      frames_o = 0;
      adjusts_o = 0;
    end else begin
      // Register writes; the start rate matters only at reset.
      if (cfg_we_i) begin
        case (blrc_pkg::cfg_idx_e'(cfg_idx_i))
          blrc_pkg::CFG_TARGET:  target_q = cfg_wdata_i[blrc_pkg::LevelW-1:0];
          blrc_pkg::CFG_ALPHA:   alpha_q = cfg_wdata_i[blrc_pkg::AlphaW-1:0];
          blrc_pkg::CFG_FLOOR:   floor_q = cfg_wdata_i[blrc_pkg::RateW-1:0];
          blrc_pkg::CFG_CEILING: ceil_q = cfg_wdata_i[blrc_pkg::RateW-1:0];
          blrc_pkg::CFG_FPA:     fpa_q = cfg_wdata_i[blrc_pkg::FpaW-1:0];
          blrc_pkg::CFG_SKEWDIV: skew_div_q = cfg_wdata_i[blrc_pkg::SkewW-1:0];
          default: ;
        endcase
      end
      // Compare an accepted result with the oldest expectation.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result count", 0, 1);
        end else begin
          exp_r = expected_results.pop_front();
          if (playback_rate_i !== exp_r.rate)
            report_mismatch("playback_rate", exp_r.rate, playback_rate_i);
          if (smoothed_level_i !== exp_r.level)
            report_mismatch("smoothed_level", exp_r.level, smoothed_level_i);
          if (trend_i !== exp_r.trend)
            report_mismatch("trend", exp_r.trend, trend_i);
          if (adjusted_i !== exp_r.adjusted)
            report_mismatch("adjusted", exp_r.adjusted, adjusted_i);
        end
      end
      // Predict the result of an accepted item.
      if (in_valid_i && !in_stall_i) begin
        exp_r = predict_frame(free_bytes_i);
        expected_results.push_back(exp_r);
        frames_o++;
        if (exp_r.adjusted) adjusts_o++;
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

  localparam int unsigned Phases = 9;
  localparam int unsigned ItemsPerPhase = 220;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned WatchdogLimit = 5000;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [blrc_pkg::CfgIdxW-1:0]       cfg_idx;
  logic [blrc_pkg::CfgDataW-1:0]      cfg_wdata;
  logic                               in_valid;
  logic                               in_stall;
  logic [blrc_pkg::LevelW-1:0]        free_bytes;
  logic                               out_valid;
  logic                               out_stall;
  logic [blrc_pkg::RateW-1:0]         playback_rate;
  logic [blrc_pkg::LevelW-1:0]        smoothed_level;
  logic signed [blrc_pkg::TrendW-1:0] trend;
  logic                               adjusted;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames_seen;
  int unsigned adjusts_seen;
  int unsigned quiet_cycles;
  logic        idle_en;
  logic        hold_req;
  logic        hold_seen;

  buffer_level_rate_controller u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .free_bytes_i    (free_bytes),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .playback_rate_o (playback_rate),
    .smoothed_level_o(smoothed_level),
    .trend_o         (trend),
    .adjusted_o      (adjusted)
  );

  blrc_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .free_bytes_i    (free_bytes),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .playback_rate_i (playback_rate),
    .smoothed_level_i(smoothed_level),
    .trend_i         (trend),
    .adjusted_i      (adjusted),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .frames_o        (frames_seen),
    .adjusts_o       (adjusts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off that backs the block up.
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      for (int i = 0; i < HoldCycles; i++) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 32);
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one frame, idling first at random, and hold it until taken.
  task automatic send_frame(logic [blrc_pkg::LevelW-1:0] value);
    logic taken;
    while (idle_en && ($urandom_range(99) < 32)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    free_bytes <= value;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drain, let the block settle, then write every register.
  task automatic program_regs(logic [blrc_pkg::CfgDataW-1:0] vals[7]);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= blrc_pkg::CfgIdxW'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [blrc_pkg::CfgDataW-1:0] regs[7];
    int level_walk;
    int step;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    free_bytes = '0;
    out_stall = 1'b0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    hold_seen = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty buffer, extremes and every input bit.
    for (int i = 0; i < 8; i++) send_frame('0);
    send_frame(14'd8192);
    send_frame(14'h3FFF);
    send_frame('0);
    send_frame(14'h2AAA);
    send_frame(14'h1555);
    for (int i = 0; i < 8; i++) send_frame(14'd8192);

    level_walk = 5000;
    for (int p = 1; p < Phases; p++) begin
      regs[blrc_pkg::CFG_TARGET] = (p == 1) ? 24'd0 : (p == 2) ? 24'd8192 :
                                   {10'($urandom), 14'($urandom_range(8192))};
      regs[blrc_pkg::CFG_ALPHA] = (p == 1 || p == 4) ? 24'd65535 : (p == 3) ? 24'd0 :
                                  {8'($urandom), 16'($urandom_range(65535, 600))};
      regs[blrc_pkg::CFG_FLOOR] = (p == 6) ? 24'd0 :
                                  24'(12288000 - $urandom_range(300000));
      regs[blrc_pkg::CFG_CEILING] = (p == 6) ? 24'hFFFFFF :
                                    24'(12288000 + $urandom_range(300000));
      // Floor above ceiling: every rate at or above the floor lands on the ceiling.
      if (p == 5) regs[blrc_pkg::CFG_FLOOR] = 24'd12400000;
      if (p == 5) regs[blrc_pkg::CFG_CEILING] = 24'd12200000;
      regs[blrc_pkg::CFG_START] = 24'($urandom);
      // A zero frame count adjusts once every sixteen frames.
      regs[blrc_pkg::CFG_FPA] = (p == 2) ? 24'd0 : (p == 3) ? 24'd1 : (p == 4) ? 24'd15 :
                                {20'($urandom), 4'($urandom_range(15, 1))};
      // A zero skew divisor acts as one.
      regs[blrc_pkg::CFG_SKEWDIV] = (p == 2) ? 24'd0 : (p == 3) ? 24'd1 :
                                    (p == 4) ? 24'd4095 :
                                    {12'($urandom), 12'($urandom_range(4095, 1))};
      program_regs(regs);
      if (p == 1) begin
        // Target zero with an empty buffer leaves the rate alone.
        cfg_we <= 1'b1;
        cfg_idx <= 3'd7;
        cfg_wdata <= 24'hFFFFFF;
        @(posedge clk);
        cfg_we <= 1'b0;
        for (int i = 0; i < 10; i++) send_frame('0);
      end
      idle_en <= (p != 8);
      if (p == 7) hold_req <= 1'b1;

      // Mostly a drifting fill level, with occasional jumps and wild values.
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if ($urandom_range(99) < 6) begin
          send_frame(14'($urandom));
        end else begin
          if ($urandom_range(99) < 5) level_walk = $urandom_range(8192);
          step = int'($urandom_range(600)) - 300;
          level_walk += step;
          if (level_walk < 0) level_walk = 0;
          if (level_walk > 8192) level_walk = 8192;
          send_frame(14'(level_walk));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk);
    $display("Covered %0d frames, %0d of them rate adjustments, over %0d register settings,",
             frames_seen, adjusts_seen, Phases);
    $display("including a long output hold-off and a stretch without idle cycles.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
